### rtl/core/sts_pkg.sv
`default_nettype none
package sts_pkg;

  localparam int COORD_W = 24;              // signed Q8.16 coordinate
  localparam int RAD_W = 23;                // unsigned Q7.16 radius
  localparam int SQ_W = 47;                 // one squared coordinate
  localparam int SUM_W = 48;                // sum of three squares
  localparam int ROOT_W = SUM_W / 2;        // floor square root of the sum
  localparam int SREM_W = ROOT_W + 1;       // square root remainder
  localparam int PROD_W = COORD_W + RAD_W;  // magnitude times radius
  localparam int QUO_W = RAD_W;             // quotient never exceeds the radius
  localparam int NUM_VERTS = 12;
  localparam int CNT_W = 4;
  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(65536);

  typedef enum logic [2:0] {
    SRC_C0,
    SRC_C1,
    SRC_C2,
    SRC_M01,
    SRC_M02,
    SRC_M12
  } src_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } vert_t;

  // One square root pipeline stage: the sum shifts out two bits per step.
  typedef struct packed {
    vert_t              v;
    logic [SUM_W-1:0]   s;
    logic [SREM_W-1:0]  rem;
    logic [ROOT_W-1:0]  root;
  } sqrt_st_t;

  typedef struct packed {
    vert_t             v;
    logic [ROOT_W-1:0] len;
  } norm_t;

  // One division pipeline stage for all three coordinates.
  typedef struct packed {
    logic [2:0][ROOT_W-1:0]        rem;
    logic [2:0][PROD_W-QUO_W-1:0]  n;
    logic [2:0][QUO_W-1:0]         q;
    logic [2:0]                    neg;
    logic [ROOT_W-1:0]             len;
    logic                          zero;
    logic                          last;
  } div_st_t;

  // Vertex order of the four output triangles.
  function automatic src_t seq_src(input logic [CNT_W-1:0] cnt);
    src_t r;
    case (cnt)
      4'd0:    r = SRC_C0;
      4'd1:    r = SRC_M01;
      4'd2:    r = SRC_M02;
      4'd3:    r = SRC_M01;
      4'd4:    r = SRC_C1;
      4'd5:    r = SRC_M12;
      4'd6:    r = SRC_M12;
      4'd7:    r = SRC_C2;
      4'd8:    r = SRC_M02;
      4'd9:    r = SRC_M12;
      4'd10:   r = SRC_M02;
      4'd11:   r = SRC_M01;
      default: r = SRC_C0;
    endcase
    return r;
  endfunction

  // Midpoint with the sum shifted right arithmetically.
  function automatic logic signed [COORD_W-1:0] mid(input logic signed [COORD_W-1:0] p,
                                                    input logic signed [COORD_W-1:0] q);
    logic signed [COORD_W:0] s;
    s = {p[COORD_W-1], p} + {q[COORD_W-1], q};
    return s[COORD_W:1];
  endfunction

endpackage
`default_nettype wire

### rtl/core/sts_if.sv
`default_nettype none
interface sts_tri_if;
  logic valid;
  logic ready;
  logic signed [23:0] ax;
  logic signed [23:0] ay;
  logic signed [23:0] az;
  logic signed [23:0] bx;
  logic signed [23:0] by;
  logic signed [23:0] bz;
  logic signed [23:0] cx;
  logic signed [23:0] cy;
  logic signed [23:0] cz;
  modport source(output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink(input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface sts_vert_if;
  logic valid;
  logic ready;
  logic signed [23:0] out_x;
  logic signed [23:0] out_y;
  logic signed [23:0] out_z;
  logic last_vertex;
  modport source(output valid, out_x, out_y, out_z, last_vertex, input ready);
  modport sink(input valid, out_x, out_y, out_z, last_vertex, output ready);
endinterface

interface sts_cfg_if;
  logic valid;
  logic ready;
  logic [22:0] sphere_radius;
  modport source(output valid, sphere_radius, input ready);
  modport sink(input valid, sphere_radius, output ready);
endinterface
`default_nettype wire

### rtl/core/sphere_triangle_subdivider.sv
`default_nettype none
// One icosphere subdivision step. Each transfer on tri_in is a triangle of
// three signed Q8.16 corners; the block answers with twelve transfers on
// vert_out, the corners and edge midpoints of four triangles in the order
// c0,m01,m02; m01,c1,m12; m12,c2,m02; m12,m02,m01, each pushed out onto the
// sphere of the programmed radius, with last_vertex set on the twelfth. One
// vertex a cycle leaves the sequencer and the output while vert_out does not
// stall; the next triangle is taken during the cycle its predecessor's last
// vertex leaves the sequencer. Between a triangle's transfer and its first
// vertex lie the sequencer, squaring and sum registers, the square root and
// division stages and the output register. A stall on vert_out freezes the
// whole pipeline. The radius is taken from cfg at any time (ready is always
// high) and must only be changed while no triangle is in flight.
module sphere_triangle_subdivider (
  input wire logic    clk,
  input wire logic    rst,
  sts_tri_if.sink     tri_in,
  sts_vert_if.source  vert_out,
  sts_cfg_if.sink     cfg
);

  logic [sts_pkg::RAD_W-1:0] radius;
  logic adv;
  sts_pkg::vert_t seq_vert;
  logic seq_valid;
  sts_pkg::norm_t norm;
  logic norm_valid;
  sts_pkg::vert_t res;
  logic res_valid;

  // The whole pipeline moves when the output register is empty or being
  // drained, so nothing is lost or repeated under back-pressure.
  assign adv = !res_valid || vert_out.ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= sts_pkg::RADIUS_RESET;
    end else if (cfg.valid) begin
      radius <= cfg.sphere_radius;
    end
  end

  // Holds the triangle and walks the twelve output vertices.
  sts_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .tri_in     (tri_in),
    .vert       (seq_vert),
    .vert_valid (seq_valid)
  );

  // Squares, their sum and a one-digit-per-stage square root.
  sts_norm u_norm (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .vin        (seq_vert),
    .vin_valid  (seq_valid),
    .nout       (norm),
    .nout_valid (norm_valid)
  );

  // Radius product and a one-bit-per-stage division by the length.
  sts_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .radius     (radius),
    .nin        (norm),
    .nin_valid  (norm_valid),
    .vout       (res),
    .vout_valid (res_valid)
  );

  assign vert_out.valid = res_valid;
  assign vert_out.out_x = res.x;
  assign vert_out.out_y = res.y;
  assign vert_out.out_z = res.z;
  assign vert_out.last_vertex = res.last;

endmodule
`default_nettype wire

### rtl/core/sts_seq.sv
`default_nettype none
module sts_seq (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         adv,
  sts_tri_if.sink           tri_in,
  output sts_pkg::vert_t    vert,
  output logic              vert_valid
);

  logic busy;
  logic [sts_pkg::CNT_W-1:0] cnt;
  logic signed [sts_pkg::COORD_W-1:0] c0x, c0y, c0z, c1x, c1y, c1z, c2x, c2y, c2z;
  logic last_slot;
  sts_pkg::vert_t sel;

  assign last_slot = (cnt == sts_pkg::CNT_W'(sts_pkg::NUM_VERTS - 1));
  assign tri_in.ready = adv && (!busy || last_slot);

  always_comb begin
    sel = '0;
    case (sts_pkg::seq_src(cnt))
      sts_pkg::SRC_C0: begin
        sel.x = c0x; sel.y = c0y; sel.z = c0z;
      end
      sts_pkg::SRC_C1: begin
        sel.x = c1x; sel.y = c1y; sel.z = c1z;
      end
      sts_pkg::SRC_C2: begin
        sel.x = c2x; sel.y = c2y; sel.z = c2z;
      end
      sts_pkg::SRC_M01: begin
        sel.x = sts_pkg::mid(c0x, c1x);
        sel.y = sts_pkg::mid(c0y, c1y);
        sel.z = sts_pkg::mid(c0z, c1z);
      end
      sts_pkg::SRC_M02: begin
        sel.x = sts_pkg::mid(c0x, c2x);
        sel.y = sts_pkg::mid(c0y, c2y);
        sel.z = sts_pkg::mid(c0z, c2z);
      end
      sts_pkg::SRC_M12: begin
        sel.x = sts_pkg::mid(c1x, c2x);
        sel.y = sts_pkg::mid(c1y, c2y);
        sel.z = sts_pkg::mid(c1z, c2z);
      end
      default: sel = '0;
    endcase
    sel.last = last_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      vert_valid <= 1'b0;
    end else if (adv) begin
      vert_valid <= busy;
      vert <= sel;
      if (tri_in.valid && tri_in.ready) begin
        busy <= 1'b1;
        cnt <= '0;
        c0x <= tri_in.ax; c0y <= tri_in.ay; c0z <= tri_in.az;
        c1x <= tri_in.bx; c1y <= tri_in.by; c1z <= tri_in.bz;
        c2x <= tri_in.cx; c2y <= tri_in.cy; c2z <= tri_in.cz;
      end else if (busy) begin
        if (last_slot) begin
          busy <= 1'b0;
          cnt <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/sts_norm.sv
`default_nettype none
module sts_norm (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire sts_pkg::vert_t  vin,
  input  wire logic            vin_valid,
  output sts_pkg::norm_t       nout,
  output logic                 nout_valid
);

  localparam int STEPS = sts_pkg::ROOT_W;

  sts_pkg::vert_t sq_v;
  logic sq_valid;
  logic [sts_pkg::SQ_W-1:0] sqx, sqy, sqz;
  logic signed [2*sts_pkg::COORD_W-1:0] px, py, pz;

  sts_pkg::sqrt_st_t st [0:STEPS];
  sts_pkg::sqrt_st_t st_next [0:STEPS-1];
  logic [STEPS:0] st_valid;

  assign px = vin.x * vin.x;
  assign py = vin.y * vin.y;
  assign pz = vin.z * vin.z;

  // One digit of the square root per stage.
  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      logic [sts_pkg::SREM_W+1:0] trial;
      logic [sts_pkg::SREM_W+1:0] cand;
      trial = {st[k].rem, st[k].s[sts_pkg::SUM_W-1 -: 2]};
      cand = (sts_pkg::SREM_W + 2)'({st[k].root, 2'b01});
      st_next[k].v = st[k].v;
      st_next[k].s = {st[k].s[sts_pkg::SUM_W-3:0], 2'b00};
      if (trial >= cand) begin
        st_next[k].rem = sts_pkg::SREM_W'(trial - cand);
        st_next[k].root = {st[k].root[sts_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        st_next[k].rem = sts_pkg::SREM_W'(trial);
        st_next[k].root = {st[k].root[sts_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      st_valid <= '0;
    end else if (adv) begin
      sq_valid <= vin_valid;
      sq_v <= vin;
      sqx <= sts_pkg::SQ_W'(px);
      sqy <= sts_pkg::SQ_W'(py);
      sqz <= sts_pkg::SQ_W'(pz);
      st_valid <= {st_valid[STEPS-1:0], sq_valid};
      st[0].v <= sq_v;
      st[0].s <= sts_pkg::SUM_W'(sqx) + sts_pkg::SUM_W'(sqy) + sts_pkg::SUM_W'(sqz);
      st[0].rem <= '0;
      st[0].root <= '0;
      for (int k = 0; k < STEPS; k++) begin
        st[k+1] <= st_next[k];
      end
    end
  end

  assign nout.v = st[STEPS].v;
  assign nout.len = st[STEPS].root;
  assign nout_valid = st_valid[STEPS];

endmodule
`default_nettype wire

### rtl/core/sts_scale.sv
`default_nettype none
module sts_scale (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  input  wire logic [sts_pkg::RAD_W-1:0]  radius,
  input  wire sts_pkg::norm_t             nin,
  input  wire logic                       nin_valid,
  output sts_pkg::vert_t                  vout,
  output logic                            vout_valid
);

  localparam int STEPS = sts_pkg::QUO_W;
  localparam int HI_W = sts_pkg::PROD_W - sts_pkg::QUO_W;

  logic [2:0][sts_pkg::COORD_W-1:0] crd;
  logic [2:0][sts_pkg::COORD_W-1:0] mag;
  logic [2:0][sts_pkg::PROD_W-1:0] prod;
  logic [2:0] neg;

  sts_pkg::div_st_t st [0:STEPS];
  sts_pkg::div_st_t st_next [0:STEPS-1];
  logic [STEPS:0] st_valid;
  logic [2:0][sts_pkg::COORD_W-1:0] res;

  assign crd[0] = nin.v.x;
  assign crd[1] = nin.v.y;
  assign crd[2] = nin.v.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i] = crd[i][sts_pkg::COORD_W-1];
      mag[i] = neg[i] ? (~crd[i] + 1'b1) : crd[i];
      prod[i] = mag[i] * radius;
    end
  end

  // One quotient bit per stage for each coordinate.
  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      st_next[k] = st[k];
      for (int i = 0; i < 3; i++) begin
        logic [sts_pkg::ROOT_W:0] t;
        t = {st[k].rem[i], st[k].n[i][HI_W-1]};
        st_next[k].n[i] = {st[k].n[i][HI_W-2:0], 1'b0};
        if (t >= {1'b0, st[k].len}) begin
          st_next[k].rem[i] = sts_pkg::ROOT_W'(t - {1'b0, st[k].len});
          st_next[k].q[i] = {st[k].q[i][sts_pkg::QUO_W-2:0], 1'b1};
        end else begin
          st_next[k].rem[i] = sts_pkg::ROOT_W'(t);
          st_next[k].q[i] = {st[k].q[i][sts_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
      vout_valid <= 1'b0;
    end else if (adv) begin
      st_valid <= {st_valid[STEPS-1:0], nin_valid};
      vout_valid <= st_valid[STEPS];
      for (int i = 0; i < 3; i++) begin
        st[0].rem[i] <= prod[i][sts_pkg::PROD_W-1 -: sts_pkg::ROOT_W];
        st[0].n[i] <= {prod[i][sts_pkg::QUO_W-1:0], (HI_W - sts_pkg::QUO_W)'(0)};
        st[0].q[i] <= '0;
      end
      st[0].neg <= neg;
      st[0].len <= nin.len;
      st[0].zero <= (nin.len == '0);
      st[0].last <= nin.v.last;
      for (int k = 0; k < STEPS; k++) begin
        st[k+1] <= st_next[k];
      end
      vout.x <= res[0];
      vout.y <= res[1];
      vout.z <= res[2];
      vout.last <= st[STEPS].last;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (st[STEPS].zero) begin
        res[i] = '0;
      end else if (st[STEPS].neg[i]) begin
        res[i] = -{1'b0, st[STEPS].q[i]};
      end else begin
        res[i] = {1'b0, st[STEPS].q[i]};
      end
    end
  end

endmodule
`default_nettype wire

### dv/tb_sphere_triangle_subdivider.sv
`default_nettype none
module tb_sphere_triangle_subdivider;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: it predicts the twelve sphere vertices of each accepted
  // triangle and compares vertex transfers against them in order.
  class vertex_scoreboard;
    sts_pkg::vert_t pending_verts[$];
    logic [sts_pkg::RAD_W-1:0] radius;
    int mismatches;

    function new();
      radius = sts_pkg::RADIUS_RESET;
      mismatches = 0;
    endfunction

    // Floor square root of a 48-bit sum of squares, digit by digit.
    function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function automatic sts_pkg::vert_t project(longint px, longint py, longint pz, bit last);
      longint c[3];
      longint unsigned sq, len, mag, quo;
      longint r[3];
      sts_pkg::vert_t v;
      c[0] = px; c[1] = py; c[2] = pz;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        mag = (c[i] < 0) ? -c[i] : c[i];
        sq += mag * mag;
      end
      len = floor_root(sq);
      for (int i = 0; i < 3; i++) begin
        r[i] = 0;
        if (len != 0) begin
          mag = (c[i] < 0) ? -c[i] : c[i];
          quo = (mag * radius) / len;
          if (c[i] < 0) r[i] = (quo > 8388608) ? -8388608 : -longint'(quo);
          else r[i] = (quo > 8388607) ? 8388607 : longint'(quo);
        end
      end
      v.x = r[0][sts_pkg::COORD_W-1:0];
      v.y = r[1][sts_pkg::COORD_W-1:0];
      v.z = r[2][sts_pkg::COORD_W-1:0];
      v.last = last;
      return v;
    endfunction

    // Note an accepted triangle: corners in p[0..2], midpoints computed here.
    function void note_triangle(longint p[3][3]);
      longint pts[6][3];
      int order[12] = '{0, 3, 4, 3, 1, 5, 5, 2, 4, 5, 4, 3};
      longint s;
      for (int k = 0; k < 3; k++) begin
        pts[0][k] = p[0][k]; pts[1][k] = p[1][k]; pts[2][k] = p[2][k];
        s = p[0][k] + p[1][k]; pts[3][k] = s >>> 1;
        s = p[0][k] + p[2][k]; pts[4][k] = s >>> 1;
        s = p[1][k] + p[2][k]; pts[5][k] = s >>> 1;
      end
      for (int i = 0; i < 12; i++)
        pending_verts.push_back(project(pts[order[i]][0], pts[order[i]][1],
                                        pts[order[i]][2], i == 11));
    endfunction

    function void check_vertex(sts_pkg::vert_t got);
      sts_pkg::vert_t exp_v;
      if (pending_verts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected vertex x=%0d y=%0d z=%0d last=%0b",
                   got.x, got.y, got.z, got.last);
        return;
      end
      exp_v = pending_verts.pop_front();
      if (got !== exp_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: vertex exp (%0d,%0d,%0d,%0b) got (%0d,%0d,%0d,%0b)",
                   exp_v.x, exp_v.y, exp_v.z, exp_v.last,
                   got.x, got.y, got.z, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  sts_tri_if tri_ch();
  sts_vert_if vert_ch();
  sts_cfg_if cfg_ch();

  sphere_triangle_subdivider uut (
    .clk(clk),
    .rst(rst),
    .tri_in(tri_ch.sink),
    .vert_out(vert_ch.source),
    .cfg(cfg_ch.sink)
  );

  vertex_scoreboard board;
  // Idle bursts on both sides are on while this is set; the final stretch
  // of the run clears it so the block runs at full rate.
  bit idling_on;
  // Long output hold-off, timed by the receiver process itself.
  bit hold_request;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: ready drops in random bursts, or for one long hold-off.
  initial begin
    int gap;
    vert_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        vert_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_request = 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        vert_ch.ready = 1'b0;
        gap = $urandom_range(1, 15);
        repeat (gap) @(negedge clk);
      end else begin
        vert_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Output monitor and watchdog, both sampled on the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (vert_ch.valid && vert_ch.ready)
        board.check_vertex('{vert_ch.out_x, vert_ch.out_y, vert_ch.out_z,
                             vert_ch.last_vertex});
      if ((vert_ch.valid && vert_ch.ready) || (tri_ch.valid && tri_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one triangle and hold it until the transfer; the scoreboard is
  // updated on the accepting edge so its queue leads every result.
  task automatic send_triangle(longint p[3][3]);
    int gap;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    tri_ch.ax = sts_pkg::COORD_W'(p[0][0]);
    tri_ch.ay = sts_pkg::COORD_W'(p[0][1]);
    tri_ch.az = sts_pkg::COORD_W'(p[0][2]);
    tri_ch.bx = sts_pkg::COORD_W'(p[1][0]);
    tri_ch.by = sts_pkg::COORD_W'(p[1][1]);
    tri_ch.bz = sts_pkg::COORD_W'(p[1][2]);
    tri_ch.cx = sts_pkg::COORD_W'(p[2][0]);
    tri_ch.cy = sts_pkg::COORD_W'(p[2][1]);
    tri_ch.cz = sts_pkg::COORD_W'(p[2][2]);
    tri_ch.valid = 1'b1;
    do @(posedge clk); while (!tri_ch.ready);
    board.note_triangle(p);
    @(negedge clk);
    tri_ch.valid = 1'b0;
  endtask

  // The register may only move while nothing is in flight: drain the
  // expected vertices, then allow the pipeline latency to settle.
  task automatic wait_drained();
    while (board.pending_verts.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_radius(logic [sts_pkg::RAD_W-1:0] value);
    cfg_ch.sphere_radius = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    board.radius = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // A random coordinate: mostly full range, sometimes near zero or an extreme.
  function automatic longint rand_coord();
    case ($urandom_range(0, 5))
      0: return longint'($urandom_range(0, 40)) - 20;
      1: return $urandom_range(0, 1) ? 64'sd8388607 - longint'($urandom_range(0, 3))
                                     : longint'($urandom_range(0, 3)) - 64'sd8388608;
      default: return longint'($urandom_range(0, 16777215)) - 8388608;
    endcase
  endfunction

  task automatic send_random(int count);
    longint p[3][3];
    repeat (count) begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) p[i][k] = rand_coord();
      // Some triangles share one corner, the degenerate case of a subdivision.
      if ($urandom_range(0, 9) == 0) p[1] = p[0];
      send_triangle(p);
    end
  endtask

  initial begin
    longint p[3][3];
    longint hi, lo;
    logic [sts_pkg::RAD_W-1:0] radii[4];
    board = new();
    hi = 8388607;
    lo = -8388608;
    idling_on = 1'b1;
    hold_request = 1'b0;
    rst = 1'b1;
    tri_ch.valid = 1'b0;
    {tri_ch.ax, tri_ch.ay, tri_ch.az} = '0;
    {tri_ch.bx, tri_ch.by, tri_ch.bz} = '0;
    {tri_ch.cx, tri_ch.cy, tri_ch.cz} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.sphere_radius = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed triangles at the reset radius: zero-length vectors, extremes
    // of every field, and midpoints of odd negative sums that round downward.
    p = '{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}};
    send_triangle(p);
    p = '{'{hi, hi, hi}, '{lo, lo, lo}, '{hi, lo, hi}};
    send_triangle(p);
    p = '{'{lo, 0, 0}, '{0, lo, 0}, '{0, 0, lo}};
    send_triangle(p);
    p = '{'{hi, 0, 0}, '{0, hi, 0}, '{0, 0, hi}};
    send_triangle(p);
    p = '{'{-1, -2, 1}, '{0, -1, -3}, '{-1, 0, 2}};
    send_triangle(p);
    p = '{'{65536, 0, 0}, '{-65536, 0, 0}, '{0, 65536, 0}};
    send_triangle(p);
    p = '{'{1, 0, 0}, '{-1, 0, 0}, '{lo, hi, lo}};
    send_triangle(p);
    send_random(8);

    // Radius sweep including both ends of the register range.
    radii = '{23'd0, 23'h7FFFFF, 23'd1, 23'd300000};
    foreach (radii[r]) begin
      wait_drained();
      write_radius(radii[r]);
      p = '{'{hi, lo, hi}, '{lo, hi, 3}, '{-5, 0, 7}};
      send_triangle(p);
      send_random(40);
    end

    // Long output hold-off while triangles keep coming: the pipeline fills
    // and the input stalls.
    wait_drained();
    write_radius(sts_pkg::RADIUS_RESET);
    hold_request = 1'b1;
    send_random(12);
    // Sender pause until every expected vertex has come back.
    while (board.pending_verts.size() != 0) @(negedge clk);

    // Final stretch at full rate with no idling.
    idling_on = 1'b0;
    send_random(30);

    while (board.pending_verts.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (board.mismatches == 0 && board.pending_verts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
rtl/core/sts_pkg.sv
rtl/core/sts_if.sv
rtl/core/sts_seq.sv
rtl/core/sts_norm.sv
rtl/core/sts_scale.sv
rtl/core/sphere_triangle_subdivider.sv
dv/tb_sphere_triangle_subdivider.sv
